// ===== hw/rtl/xtea_pkg.sv =====
// ============================================================================
// xtea_pkg
// Shared types and constants for the pipelined XTEA block cipher core.
// ============================================================================
package xtea_pkg;

    // Round constant and key-select shift
    localparam logic [31:0] XTEA_DELTA    = 32'h9e3779b9;
    localparam int          KEY_SEL_SHIFT = 11;

    // Opcodes
    localparam logic OP_ENCRYPT = 1'b0;
    localparam logic OP_DECRYPT = 1'b1;

    // Configuration register indexes
    localparam int CFG_INDEX_W = 2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD0 = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD1 = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD2 = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_KEY_WORD3 = 2'd3;

    // 128-bit key as four words, word 0 in the low slot
    typedef logic [3:0][31:0] xtea_key_t;

    // Input request payload
    typedef struct packed {
        logic        opcode;
        logic [31:0] block_low;
        logic [31:0] block_high;
        logic [3:0]  byte_count;
    } xtea_in_t;

    // Result payload
    typedef struct packed {
        logic [31:0] result_low;
        logic [31:0] result_high;
        logic        length_error;
    } xtea_out_t;

    // Contents of one pipeline stage
    typedef struct packed {
        logic        valid;
        logic        op;
        logic        err;
        logic [31:0] v0;
        logic [31:0] v1;
    } xtea_stage_t;

endpackage

// ===== hw/rtl/xtea_pad.sv =====
// ============================================================================
// xtea_pad
// Entry stage: zeroes missing bytes of a partial encrypt block and flags
// decrypt requests on partial blocks.
// ============================================================================
module xtea_pad (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              adv,
    input  logic              req_valid,
    input  xtea_pkg::xtea_in_t req,
    output xtea_pkg::xtea_stage_t stage_out
);
    import xtea_pkg::*;

    logic        valid_reg;
    logic        op_reg;
    logic        err_reg;
    logic [31:0] v0_reg;
    logic [31:0] v1_reg;

    logic        partial;
    logic [63:0] keep_mask;
    logic [63:0] blk;
    logic [63:0] v_next;
    logic        err_next;

    // Byte keep mask: a count of eight or more keeps the whole block
    always_comb
    begin
        partial = ~req.byte_count[3];
        for (int b = 0; b < 8; b++)
        begin
            keep_mask[b*8 +: 8] = {8{~partial || (3'(b) < req.byte_count[2:0])}};
        end
        blk = {req.block_high, req.block_low};
        if (req.opcode == OP_ENCRYPT)
        begin
            v_next   = blk & keep_mask;
            err_next = 1'b0;
        end
        else
        begin
            v_next   = blk;
            err_next = partial;
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg <= req.opcode;
            err_reg <= err_next;
            v0_reg <= v_next[31:0];
            v1_reg <= v_next[63:32];
        end
    end

    assign stage_out = '{valid: valid_reg, op: op_reg, err: err_reg,
                         v0: v0_reg, v1: v1_reg};

endmodule

// ===== hw/rtl/xtea_half_round.sv =====
// ============================================================================
// xtea_half_round
// One registered Feistel half round. Encrypt and decrypt share the stage:
// the round sum and key word are fixed per stage and chosen by the opcode.
// ============================================================================
module xtea_half_round #(
    parameter int CYCLE_COUNT = 32,
    parameter int HALF_INDEX  = 0
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  xtea_pkg::xtea_key_t   key,
    input  xtea_pkg::xtea_stage_t stage_in,
    output xtea_pkg::xtea_stage_t stage_out
);
    import xtea_pkg::*;

    // Round sum seen by this half round in each direction
    localparam int          SUM_STEP = (HALF_INDEX + 1) / 2;
    localparam logic        PARITY   = 1'(HALF_INDEX % 2);
    localparam logic [63:0] ENC_PROD = 64'(XTEA_DELTA) * 64'(SUM_STEP);
    localparam logic [63:0] DEC_PROD = 64'(XTEA_DELTA) * 64'(CYCLE_COUNT - SUM_STEP);
    localparam logic [31:0] ENC_SUM  = ENC_PROD[31:0];
    localparam logic [31:0] DEC_SUM  = DEC_PROD[31:0];
    // Updating v1 selects the key with the shifted sum, updating v0 with the low bits
    localparam logic [31:0] ENC_SHR  = ENC_SUM >> KEY_SEL_SHIFT;
    localparam logic [31:0] DEC_SHR  = DEC_SUM >> KEY_SEL_SHIFT;
    localparam logic [1:0]  ENC_KEY  = PARITY ? ENC_SHR[1:0] : ENC_SUM[1:0];
    localparam logic [1:0]  DEC_KEY  = PARITY ? DEC_SUM[1:0] : DEC_SHR[1:0];

    logic        valid_reg;
    logic        op_reg;
    logic        err_reg;
    logic [31:0] v0_reg;
    logic [31:0] v1_reg;

    logic        upd_v1;
    logic [31:0] src;
    logic [31:0] dst;
    logic [31:0] mix;
    logic [31:0] key_sum;
    logic [31:0] f_val;
    logic [31:0] dst_next;
    logic [31:0] v0_next;
    logic [31:0] v1_next;

    // Round function and update of the target word
    always_comb
    begin
        upd_v1  = stage_in.op ^ PARITY;
        src     = upd_v1 ? stage_in.v0 : stage_in.v1;
        dst     = upd_v1 ? stage_in.v1 : stage_in.v0;
        mix     = ((src << 4) ^ (src >> 5)) + src;
        key_sum = (stage_in.op == OP_DECRYPT) ? (DEC_SUM + key[DEC_KEY])
                                              : (ENC_SUM + key[ENC_KEY]);
        f_val   = mix ^ key_sum;
        if (stage_in.err)
        begin
            dst_next = dst;  // partial decrypt passes through
        end
        else if (stage_in.op == OP_DECRYPT)
        begin
            dst_next = dst - f_val;
        end
        else
        begin
            dst_next = dst + f_val;
        end
        v0_next = upd_v1 ? stage_in.v0 : dst_next;
        v1_next = upd_v1 ? dst_next : stage_in.v1;
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg <= stage_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            op_reg <= stage_in.op;
            err_reg <= stage_in.err;
            v0_reg <= v0_next;
            v1_reg <= v1_next;
        end
    end

    assign stage_out = '{valid: valid_reg, op: op_reg, err: err_reg,
                         v0: v0_reg, v1: v1_reg};

endmodule

// ===== hw/rtl/xtea_block_cipher_core.sv =====
// Throughput: one block per unstalled cycle; one pad stage, one register per Feistel
// half round, and an output register that holds a result while out_stall is high.
// A stalled output freezes the whole pipeline and raises in_stall.
// Reset clears all stage valid bits and the key words to zero.
// ============================================================================
// xtea_block_cipher_core
// Fully unrolled XTEA encrypt/decrypt pipeline, ECB, key in four registers.
// ============================================================================
module xtea_block_cipher_core #(
    parameter int CYCLE_COUNT = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // Block requests
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  xtea_pkg::xtea_in_t                   in_data,
    // Results
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output xtea_pkg::xtea_out_t                  out_data,
    // Key register writes
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [xtea_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [31:0]                          cfg_data
);
    import xtea_pkg::*;

    localparam int HALF_COUNT = 2 * CYCLE_COUNT;

    xtea_key_t   key_reg;
    xtea_stage_t pipe [0:HALF_COUNT];
    logic        adv;
    logic        out_valid_reg;
    xtea_out_t   out_data_reg;

    // Pipeline moves unless a held result is being stalled
    assign adv       = ~(out_valid_reg & out_stall);
    assign in_stall  = ~adv;
    assign cfg_ready = 1'b1;

    // Key registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_KEY_WORD0: key_reg[0] <= cfg_data;
                CFG_KEY_WORD1: key_reg[1] <= cfg_data;
                CFG_KEY_WORD2: key_reg[2] <= cfg_data;
                CFG_KEY_WORD3: key_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    // Entry stage
    xtea_pad u_pad (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .req_valid (in_valid),
        .req       (in_data),
        .stage_out (pipe[0])
    );

    // Half-round stages
    for (genvar h = 0; h < HALF_COUNT; h++)
    begin : g_round
        xtea_half_round #(
            .CYCLE_COUNT (CYCLE_COUNT),
            .HALF_INDEX  (h)
        ) u_half (
            .clk       (clk),
            .rst_n     (rst_n),
            .adv       (adv),
            .key       (key_reg),
            .stage_in  (pipe[h]),
            .stage_out (pipe[h+1])
        );
    end

    // Output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= pipe[HALF_COUNT].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg.result_low   <= pipe[HALF_COUNT].v0;
            out_data_reg.result_high  <= pipe[HALF_COUNT].v1;
            out_data_reg.length_error <= pipe[HALF_COUNT].err;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    // Checks
    a_last_to_out: assert property (@(posedge clk) disable iff (!rst_n)
        adv && pipe[HALF_COUNT].valid |=> out_valid_reg)
        else $error("finished block not moved to output register");

    a_pipe_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !adv |=> $stable(pipe[1]) && $stable(pipe[HALF_COUNT]))
        else $error("pipeline stage changed during stall");

    a_err_decrypt: assert property (@(posedge clk) disable iff (!rst_n)
        pipe[HALF_COUNT].valid && pipe[HALF_COUNT].err |-> pipe[HALF_COUNT].op == OP_DECRYPT)
        else $error("length error on an encrypt request");

    a_key_write: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready && cfg_index == CFG_KEY_WORD0 |=> key_reg[0] == $past(cfg_data))
        else $error("key word 0 not written");

endmodule
